// ===== rtl/imhq_pkg.sv =====
// shared types and codes for the indexed min-heap queue
// no dependencies; used by imhq_key_cmp and indexed_min_heap_queue
package imhq_pkg;

    localparam int VERTEX_BITS = 10;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_POP    = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_LOOKUP = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_LOOK,
        S_UPD,
        S_LKW,
        S_RM,
        S_RMW,
        S_UP,
        S_UPC,
        S_DN,
        S_DNL,
        S_DNR,
        S_DNX,
        S_PLACE,
        S_TOP,
        S_TOPW
    } state_t;

    // result of the shared key comparator
    typedef struct packed {
        logic less;
        logic equal;
    } cmp_t;

endpackage

// ===== rtl/imhq_key_cmp.sv =====
// lexicographic key comparator, primary part first, secondary breaks ties
// depends on imhq_pkg (cmp_t)
module imhq_key_cmp #(
    parameter int KEY_BITS = 32
) (
    input  logic [KEY_BITS-1:0] a_p,
    input  logic [KEY_BITS-1:0] a_s,
    input  logic [KEY_BITS-1:0] b_p,
    input  logic [KEY_BITS-1:0] b_s,
    output imhq_pkg::cmp_t      res
);

    always_comb
    begin
        res.less  = (a_p < b_p) || ((a_p == b_p) && (a_s < b_s));
        res.equal = (a_p == b_p) && (a_s == b_s);
    end

endmodule

// ===== rtl/indexed_min_heap_queue.sv =====
// indexed binary min-heap with decrease/increase key, top level and sequencer
// depends on imhq_pkg and imhq_key_cmp
//
// channel  dir  signals                 contents
// s_       in   tvalid tready tdata     tdata: vertex, key_primary, key_secondary
//                      tuser            tuser: operation
// m_       out  tvalid tready tdata     tdata: result and top entry, entry_count
//                      tuser            tuser: status, found
//
// one item at a time; sift up and sift down move one heap level per step,
// paced by the single slot memory read port and the one key comparator.
// after reset and after a clear op the presence flags are swept, one vertex
// per cycle, with s_tready low.
// a finished result waits in the output register while the next item starts.
module indexed_min_heap_queue #(
    parameter int HEAP_SLOTS   = 256,
    parameter int VERTEX_COUNT = 1024,
    parameter int KEY_BITS     = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // vertex[9:0], key_primary[41:10], key_secondary[73:42]
    input  logic [2:0]   s_tuser,   // operation[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // result_vertex[9:0], result_key_primary[41:10],
                                    // result_key_secondary[73:42], top_vertex[83:74],
                                    // top_key_primary[115:84], top_key_secondary[147:116],
                                    // entry_count[156:148]
    output logic [2:0]   m_tuser    // status[1:0], found[2]
);

    localparam int VB  = imhq_pkg::VERTEX_BITS;
    localparam int KB  = KEY_BITS;
    localparam int SW  = $clog2(HEAP_SLOTS);
    localparam int CW  = $clog2(HEAP_SLOTS + 1);
    localparam int VIW = $clog2(VERTEX_COUNT);
    localparam int EW  = VB + 2 * KB;
    localparam logic [KB-1:0] KEY_INF = {KB{1'b1}};

    // memories
    logic [EW-1:0]  slot_mem [HEAP_SLOTS];
    logic [SW-1:0]  pos_mem  [VERTEX_COUNT];
    logic           pres_mem [VERTEX_COUNT];

    logic [EW-1:0]  slot_q;
    logic [SW-1:0]  pos_q;
    logic           pres_q;

    logic           slot_re, slot_we;
    logic [SW-1:0]  slot_raddr, slot_waddr;
    logic [EW-1:0]  slot_wdata;
    logic           pos_we;
    logic [VIW-1:0] pos_waddr;
    logic [SW-1:0]  pos_wdata;
    logic           pres_we;
    logic [VIW-1:0] pres_waddr;
    logic           pres_wdata;

    // control state
    imhq_pkg::state_t state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [VIW-1:0] clr_idx_reg, clr_idx_next;
    logic           cl_op_reg, cl_op_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic           dn_after_reg, dn_after_next;
    logic           moved_reg, moved_next;
    logic           best_child_reg, best_child_next;

    // payload
    logic [2:0]     op_reg, op_next;
    logic [VB-1:0]  vtx_reg, vtx_next;
    logic [KB-1:0]  kp_reg, kp_next, ks_reg, ks_next;
    logic [SW-1:0]  hole_reg, hole_next;
    logic [VB-1:0]  cur_v_reg, cur_v_next;
    logic [KB-1:0]  cur_p_reg, cur_p_next, cur_s_reg, cur_s_next;
    logic [VB-1:0]  best_v_reg, best_v_next;
    logic [KB-1:0]  best_p_reg, best_p_next, best_s_reg, best_s_next;
    logic [SW-1:0]  best_idx_reg, best_idx_next;
    logic [1:0]     status_reg, status_next;
    logic           found_reg, found_next;
    logic [VB-1:0]  res_v_reg, res_v_next;
    logic [KB-1:0]  res_p_reg, res_p_next, res_s_reg, res_s_next;
    logic [159:0]   m_tdata_reg;
    logic [2:0]     m_tuser_reg;
    logic           out_load;

    // slot word fields
    logic [VB-1:0]  q_v;
    logic [KB-1:0]  q_p, q_s;
    assign q_v = slot_q[VB-1:0];
    assign q_p = slot_q[VB +: KB];
    assign q_s = slot_q[VB+KB +: KB];

    logic [VIW-1:0] in_vidx;
    logic           accept;
    logic           vtx_ok;
    logic           present;
    logic [SW:0]    left_idx, right_idx;
    logic [SW-1:0]  parent_idx;

    assign in_vidx    = VIW'(s_tdata[VB-1:0]);
    assign accept     = s_tvalid && s_tready;
    assign vtx_ok     = 32'(vtx_reg) < 32'(VERTEX_COUNT);
    assign present    = vtx_ok && pres_q;
    assign left_idx   = {hole_reg, 1'b1};
    assign right_idx  = left_idx + (SW+1)'(1);
    assign parent_idx = SW'((hole_reg - SW'(1)) >> 1);

    // shared comparator with input selection
    logic [KB-1:0]   ca_p, ca_s, cb_p, cb_s;
    imhq_pkg::cmp_t  cmp;

    imhq_key_cmp #(.KEY_BITS(KB)) u_cmp (
        .a_p (ca_p),
        .a_s (ca_s),
        .b_p (cb_p),
        .b_s (cb_s),
        .res (cmp)
    );

    always_comb
    begin
        ca_p = q_p;
        ca_s = q_s;
        cb_p = cur_p_reg;
        cb_s = cur_s_reg;
        case (state_reg)
            imhq_pkg::S_UPD:
            begin
                ca_p = kp_reg;
                ca_s = ks_reg;
                cb_p = q_p;
                cb_s = q_s;
            end
            imhq_pkg::S_UPC:
            begin
                ca_p = cur_p_reg;
                ca_s = cur_s_reg;
                cb_p = q_p;
                cb_s = q_s;
            end
            imhq_pkg::S_DNR:
            begin
                cb_p = best_p_reg;
                cb_s = best_s_reg;
            end
            default:
            begin
            end
        endcase
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        if (slot_re)
            slot_q <= slot_mem[slot_raddr];
        if (pos_we)
            pos_mem[pos_waddr] <= pos_wdata;
        if (pres_we)
            pres_mem[pres_waddr] <= pres_wdata;
        if (accept)
        begin
            pos_q  <= pos_mem[in_vidx];
            pres_q <= pres_mem[in_vidx];
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        clr_idx_next    = clr_idx_reg;
        cl_op_next      = cl_op_reg;
        dn_after_next   = dn_after_reg;
        moved_next      = moved_reg;
        best_child_next = best_child_reg;
        op_next         = op_reg;
        vtx_next        = vtx_reg;
        kp_next         = kp_reg;
        ks_next         = ks_reg;
        hole_next       = hole_reg;
        cur_v_next      = cur_v_reg;
        cur_p_next      = cur_p_reg;
        cur_s_next      = cur_s_reg;
        best_v_next     = best_v_reg;
        best_p_next     = best_p_reg;
        best_s_next     = best_s_reg;
        best_idx_next   = best_idx_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        res_v_next      = res_v_reg;
        res_p_next      = res_p_reg;
        res_s_next      = res_s_reg;
        s_tready        = 1'b0;
        out_load        = 1'b0;
        slot_re         = 1'b0;
        slot_raddr      = '0;
        slot_we         = 1'b0;
        slot_waddr      = hole_reg;
        slot_wdata      = {cur_s_reg, cur_p_reg, cur_v_reg};
        pos_we          = 1'b0;
        pos_waddr       = VIW'(cur_v_reg);
        pos_wdata       = hole_reg;
        pres_we         = 1'b0;
        pres_waddr      = VIW'(vtx_reg);
        pres_wdata      = 1'b0;

        case (state_reg)
            imhq_pkg::S_CLR:
            begin
                pres_we    = 1'b1;
                pres_waddr = clr_idx_reg;
                pres_wdata = 1'b0;
                clr_idx_next = clr_idx_reg + VIW'(1);
                if (clr_idx_reg == VIW'(VERTEX_COUNT - 1))
                begin
                    clr_idx_next = '0;
                    cl_op_next   = 1'b0;
                    state_next   = cl_op_reg ? imhq_pkg::S_TOP : imhq_pkg::S_IDLE;
                end
            end

            imhq_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next     = s_tuser;
                    vtx_next    = s_tdata[VB-1:0];
                    kp_next     = s_tdata[10 +: KB];
                    ks_next     = s_tdata[42 +: KB];
                    status_next = imhq_pkg::ST_OK;
                    found_next  = 1'b0;
                    res_v_next  = '0;
                    res_p_next  = KEY_INF;
                    res_s_next  = KEY_INF;
                    // root is needed by pop
                    slot_re     = 1'b1;
                    slot_raddr  = '0;
                    state_next  = imhq_pkg::S_LOOK;
                end
            end

            imhq_pkg::S_LOOK:
            begin
                state_next = imhq_pkg::S_TOP;
                case (op_reg)
                    imhq_pkg::OP_INSERT:
                    begin
                        if (!vtx_ok)
                            status_next = imhq_pkg::ST_ABSENT;
                        else if (present)
                        begin
                            slot_re    = 1'b1;
                            slot_raddr = pos_q;
                            hole_next  = pos_q;
                            state_next = imhq_pkg::S_UPD;
                        end
                        else if (cnt_reg == CW'(HEAP_SLOTS))
                            status_next = imhq_pkg::ST_FULL;
                        else
                        begin
                            pres_we       = 1'b1;
                            pres_wdata    = 1'b1;
                            hole_next     = SW'(cnt_reg);
                            cnt_next      = cnt_reg + CW'(1);
                            cur_v_next    = vtx_reg;
                            cur_p_next    = kp_reg;
                            cur_s_next    = ks_reg;
                            dn_after_next = 1'b0;
                            moved_next    = 1'b0;
                            state_next    = imhq_pkg::S_UP;
                        end
                    end
                    imhq_pkg::OP_REMOVE:
                    begin
                        if (!present)
                            status_next = imhq_pkg::ST_ABSENT;
                        else
                        begin
                            pres_we    = 1'b1;
                            hole_next  = pos_q;
                            cnt_next   = cnt_reg - CW'(1);
                            state_next = imhq_pkg::S_RM;
                        end
                    end
                    imhq_pkg::OP_POP:
                    begin
                        if (cnt_reg == '0)
                            status_next = imhq_pkg::ST_EMPTY;
                        else
                        begin
                            found_next = 1'b1;
                            res_v_next = q_v;
                            res_p_next = q_p;
                            res_s_next = q_s;
                            pres_we    = 1'b1;
                            pres_waddr = VIW'(q_v);
                            hole_next  = '0;
                            cnt_next   = cnt_reg - CW'(1);
                            state_next = imhq_pkg::S_RM;
                        end
                    end
                    imhq_pkg::OP_CLEAR:
                    begin
                        cnt_next     = '0;
                        cl_op_next   = 1'b1;
                        clr_idx_next = '0;
                        state_next   = imhq_pkg::S_CLR;
                    end
                    imhq_pkg::OP_LOOKUP:
                    begin
                        if (!present)
                            status_next = imhq_pkg::ST_ABSENT;
                        else
                        begin
                            slot_re    = 1'b1;
                            slot_raddr = pos_q;
                            state_next = imhq_pkg::S_LKW;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            imhq_pkg::S_LKW:
            begin
                found_next = 1'b1;
                res_v_next = vtx_reg;
                res_p_next = q_p;
                res_s_next = q_s;
                state_next = imhq_pkg::S_TOP;
            end

            imhq_pkg::S_UPD:
            begin
                cur_v_next    = vtx_reg;
                cur_p_next    = kp_reg;
                cur_s_next    = ks_reg;
                dn_after_next = 1'b0;
                moved_next    = 1'b0;
                if (cmp.less)
                    state_next = imhq_pkg::S_UP;
                else if (cmp.equal)
                    state_next = imhq_pkg::S_TOP;
                else
                    state_next = imhq_pkg::S_DN;
            end

            imhq_pkg::S_RM:
            begin
                // cnt_reg already holds the index of the last entry
                if (CW'(hole_reg) == cnt_reg)
                    state_next = imhq_pkg::S_TOP;
                else
                begin
                    slot_re    = 1'b1;
                    slot_raddr = SW'(cnt_reg);
                    state_next = imhq_pkg::S_RMW;
                end
            end

            imhq_pkg::S_RMW:
            begin
                cur_v_next    = q_v;
                cur_p_next    = q_p;
                cur_s_next    = q_s;
                dn_after_next = 1'b1;
                moved_next    = 1'b0;
                state_next    = imhq_pkg::S_UP;
            end

            imhq_pkg::S_UP:
            begin
                if (hole_reg == '0)
                    state_next = (dn_after_reg && !moved_reg) ? imhq_pkg::S_DN
                                                              : imhq_pkg::S_PLACE;
                else
                begin
                    slot_re    = 1'b1;
                    slot_raddr = parent_idx;
                    state_next = imhq_pkg::S_UPC;
                end
            end

            imhq_pkg::S_UPC:
            begin
                if (cmp.less)
                begin
                    // parent drops into the hole
                    slot_we    = 1'b1;
                    slot_wdata = slot_q;
                    pos_we     = 1'b1;
                    pos_waddr  = VIW'(q_v);
                    hole_next  = parent_idx;
                    moved_next = 1'b1;
                    state_next = imhq_pkg::S_UP;
                end
                else if (dn_after_reg && !moved_reg)
                    state_next = imhq_pkg::S_DN;
                else
                    state_next = imhq_pkg::S_PLACE;
            end

            imhq_pkg::S_DN:
            begin
                best_child_next = 1'b0;
                best_v_next     = cur_v_reg;
                best_p_next     = cur_p_reg;
                best_s_next     = cur_s_reg;
                if (left_idx >= (SW+1)'(cnt_reg))
                    state_next = imhq_pkg::S_PLACE;
                else
                begin
                    slot_re    = 1'b1;
                    slot_raddr = SW'(left_idx);
                    state_next = imhq_pkg::S_DNL;
                end
            end

            imhq_pkg::S_DNL:
            begin
                if (cmp.less)
                begin
                    best_child_next = 1'b1;
                    best_v_next     = q_v;
                    best_p_next     = q_p;
                    best_s_next     = q_s;
                    best_idx_next   = SW'(left_idx);
                end
                if (right_idx < (SW+1)'(cnt_reg))
                begin
                    slot_re    = 1'b1;
                    slot_raddr = SW'(right_idx);
                    state_next = imhq_pkg::S_DNR;
                end
                else
                    state_next = imhq_pkg::S_DNX;
            end

            imhq_pkg::S_DNR:
            begin
                if (cmp.less)
                begin
                    best_child_next = 1'b1;
                    best_v_next     = q_v;
                    best_p_next     = q_p;
                    best_s_next     = q_s;
                    best_idx_next   = SW'(right_idx);
                end
                state_next = imhq_pkg::S_DNX;
            end

            imhq_pkg::S_DNX:
            begin
                if (!best_child_reg)
                    state_next = imhq_pkg::S_PLACE;
                else
                begin
                    // smaller child rises into the hole
                    slot_we    = 1'b1;
                    slot_wdata = {best_s_reg, best_p_reg, best_v_reg};
                    pos_we     = 1'b1;
                    pos_waddr  = VIW'(best_v_reg);
                    hole_next  = best_idx_reg;
                    state_next = imhq_pkg::S_DN;
                end
            end

            imhq_pkg::S_PLACE:
            begin
                slot_we    = 1'b1;
                pos_we     = 1'b1;
                state_next = imhq_pkg::S_TOP;
            end

            imhq_pkg::S_TOP:
            begin
                slot_re    = 1'b1;
                slot_raddr = '0;
                state_next = imhq_pkg::S_TOPW;
            end

            imhq_pkg::S_TOPW:
            begin
                // slot_q holds while waiting for the output register
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = imhq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = imhq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= imhq_pkg::S_CLR;
            cnt_reg        <= '0;
            clr_idx_reg    <= '0;
            cl_op_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            dn_after_reg   <= 1'b0;
            moved_reg      <= 1'b0;
            best_child_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            clr_idx_reg    <= clr_idx_next;
            cl_op_reg      <= cl_op_next;
            m_tvalid_reg   <= m_tvalid_next;
            dn_after_reg   <= dn_after_next;
            moved_reg      <= moved_next;
            best_child_reg <= best_child_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        vtx_reg      <= vtx_next;
        kp_reg       <= kp_next;
        ks_reg       <= ks_next;
        hole_reg     <= hole_next;
        cur_v_reg    <= cur_v_next;
        cur_p_reg    <= cur_p_next;
        cur_s_reg    <= cur_s_next;
        best_v_reg   <= best_v_next;
        best_p_reg   <= best_p_next;
        best_s_reg   <= best_s_next;
        best_idx_reg <= best_idx_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        res_v_reg    <= res_v_next;
        res_p_reg    <= res_p_next;
        res_s_reg    <= res_s_next;
        if (out_load)
        begin
            m_tuser_reg <= {found_reg, status_reg};
            m_tdata_reg <= {3'b0, 9'(cnt_reg),
                            32'((cnt_reg == '0) ? KEY_INF : q_s),
                            32'((cnt_reg == '0) ? KEY_INF : q_p),
                            (cnt_reg == '0) ? {VB{1'b0}} : q_v,
                            32'(res_s_reg), 32'(res_p_reg), res_v_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== bench/indexed_min_heap_queue_tb.sv =====
// self-checking bench for the indexed min-heap queue: directed and random ops,
// scored against a behavioral heap kept in the bench. depends on imhq_pkg
`timescale 1ns / 1ps

module indexed_min_heap_queue_tb;

    localparam int SLOTS = 256;
    localparam int VERTS = 1024;
    localparam logic [31:0] KEY_INF = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  op;
        logic [9:0]  vertex;
        logic [31:0] kp;
        logic [31:0] ks;
    } heap_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [9:0]  rv;
        logic [31:0] rp;
        logic [31:0] rs;
        logic [9:0]  tv;
        logic [31:0] tp;
        logic [31:0] ts;
        logic [8:0]  cnt;
    } heap_rsp_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;
    logic [2:0]   m_tuser;

    indexed_min_heap_queue dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // behavioral heap
    logic [31:0] hp_kp [SLOTS];
    logic [31:0] hp_ks [SLOTS];
    logic [9:0]  hp_v  [SLOTS];
    int          pos_of [VERTS];
    bit          live [VERTS];
    int          occ;

    heap_req_t   pending_reqs[$];
    heap_rsp_t   expected_rsps[$];
    int          errors;
    bit          hold_sender;
    int          rx_hold;

    function automatic bit key_lt(logic [31:0] ap, logic [31:0] as_,
                                  logic [31:0] bp, logic [31:0] bs);
        return (ap < bp) || (ap == bp && as_ < bs);
    endfunction

    function automatic bit slot_lt(int a, int b);
        return key_lt(hp_kp[a], hp_ks[a], hp_kp[b], hp_ks[b]);
    endfunction

    function automatic void swap_slot(int a, int b);
        logic [31:0] p, s;
        logic [9:0]  v;
        p = hp_kp[a]; s = hp_ks[a]; v = hp_v[a];
        hp_kp[a] = hp_kp[b]; hp_ks[a] = hp_ks[b]; hp_v[a] = hp_v[b];
        hp_kp[b] = p; hp_ks[b] = s; hp_v[b] = v;
        pos_of[hp_v[a]] = a;
        pos_of[hp_v[b]] = b;
    endfunction

    function automatic void bubble_up(int i);
        int par;
        while (i > 0)
        begin
            par = (i - 1) / 2;
            if (!slot_lt(i, par))
                break;
            swap_slot(i, par);
            i = par;
        end
    endfunction

    function automatic void bubble_down(int i);
        int best, l;
        forever
        begin
            best = i;
            l = 2 * i + 1;
            if (l < occ && slot_lt(l, best))
                best = l;
            if (l + 1 < occ && slot_lt(l + 1, best))
                best = l + 1;
            if (best == i)
                break;
            swap_slot(i, best);
            i = best;
        end
    endfunction

    function automatic void drop_vertex(int v);
        int p, last;
        p = pos_of[v];
        last = occ - 1;
        live[v] = 0;
        occ = last;
        if (p != last)
        begin
            hp_kp[p] = hp_kp[last]; hp_ks[p] = hp_ks[last]; hp_v[p] = hp_v[last];
            pos_of[hp_v[p]] = p;
            bubble_up(p);
            bubble_down(p);
        end
    endfunction

    function automatic heap_rsp_t predict_heap_op(heap_req_t r);
        heap_rsp_t   e;
        int          v, p;
        logic [31:0] op_, os;
        v = int'(r.vertex);
        e = '0;
        e.rp = KEY_INF;
        e.rs = KEY_INF;
        e.status = imhq_pkg::ST_OK;
        case (r.op)
            imhq_pkg::OP_INSERT:
                if (live[v])
                begin
                    p = pos_of[v];
                    op_ = hp_kp[p]; os = hp_ks[p];
                    hp_kp[p] = r.kp; hp_ks[p] = r.ks;
                    if (key_lt(r.kp, r.ks, op_, os))
                        bubble_up(p);
                    else if (key_lt(op_, os, r.kp, r.ks))
                        bubble_down(p);
                end
                else if (occ >= SLOTS)
                    e.status = imhq_pkg::ST_FULL;
                else
                begin
                    p = occ;
                    hp_kp[p] = r.kp; hp_ks[p] = r.ks; hp_v[p] = 10'(v);
                    pos_of[v] = p;
                    live[v] = 1;
                    occ++;
                    bubble_up(p);
                end
            imhq_pkg::OP_REMOVE:
                if (live[v])
                    drop_vertex(v);
                else
                    e.status = imhq_pkg::ST_ABSENT;
            imhq_pkg::OP_POP:
                if (occ == 0)
                    e.status = imhq_pkg::ST_EMPTY;
                else
                begin
                    e.found = 1;
                    e.rv = hp_v[0]; e.rp = hp_kp[0]; e.rs = hp_ks[0];
                    drop_vertex(int'(hp_v[0]));
                end
            imhq_pkg::OP_CLEAR:
            begin
                occ = 0;
                foreach (live[i])
                    live[i] = 0;
            end
            imhq_pkg::OP_LOOKUP:
                if (live[v])
                begin
                    p = pos_of[v];
                    e.found = 1;
                    e.rv = 10'(v); e.rp = hp_kp[p]; e.rs = hp_ks[p];
                end
                else
                    e.status = imhq_pkg::ST_ABSENT;
            default: ;
        endcase
        if (occ > 0)
        begin
            e.tv = hp_v[0]; e.tp = hp_kp[0]; e.ts = hp_ks[0];
        end
        else
        begin
            e.tv = '0; e.tp = KEY_INF; e.ts = KEY_INF;
        end
        e.cnt = occ[8:0];
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic heap_req_t mk(int op, int v, logic [31:0] kp, logic [31:0] ks);
        heap_req_t r;
        r.op = 3'(op); r.vertex = 10'(v); r.kp = kp; r.ks = ks;
        return r;
    endfunction

    function automatic void queue_req(heap_req_t r);
        pending_reqs = {pending_reqs, r};
    endfunction

    // keys drawn from a narrow range often, so ties on the primary are common
    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return KEY_INF;
            2: return 32'h0;
            default: return $urandom_range(0, 40) << 16;
        endcase
    endfunction

    always #2 clk = ~clk;

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_reqs.size() > 0 && !hold_sender && $urandom_range(0, 3) != 0)
            begin
                heap_req_t r;
                r = pending_reqs.pop_front();
                expected_rsps = {expected_rsps, predict_heap_op(r)};
                s_tvalid <= 1'b1;
                s_tuser  <= r.op;
                s_tdata  <= {6'b0, r.ks, r.kp, r.vertex};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver ready, with long holds now and then or when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (rx_hold > 0)
        begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 499) == 0)
                rx_hold <= $urandom_range(20, 120);
            m_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            heap_rsp_t got, want;
            got.status = m_tuser[1:0];
            got.found  = m_tuser[2];
            {got.cnt, got.ts, got.tp, got.tv, got.rs, got.rp, got.rv} = m_tdata[156:0];
            if (expected_rsps.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.found != want.found)
                    report_mismatch("found", 32'(got.found), 32'(want.found));
                if (got.rv != want.rv)
                    report_mismatch("result_vertex", 32'(got.rv), 32'(want.rv));
                if (got.rp != want.rp)         report_mismatch("result_key_p", got.rp, want.rp);
                if (got.rs != want.rs)         report_mismatch("result_key_s", got.rs, want.rs);
                if (got.tv != want.tv)
                    report_mismatch("top_vertex", 32'(got.tv), 32'(want.tv));
                if (got.tp != want.tp)         report_mismatch("top_key_p", got.tp, want.tp);
                if (got.ts != want.ts)         report_mismatch("top_key_s", got.ts, want.ts);
                if (got.cnt != want.cnt)
                    report_mismatch("entry_count", 32'(got.cnt), 32'(want.cnt));
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_tvalid || expected_rsps.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int v;
        clk = 0;
        rst_n = 0;
        errors = 0;
        rx_hold = 0;
        hold_sender = 0;
        occ = 0;
        foreach (live[i])
            live[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;

        // directed: empty cases, key extremes, ties, updates both ways, unused op codes, clear
        queue_req(mk(imhq_pkg::OP_POP, 0, 0, 0));
        queue_req(mk(imhq_pkg::OP_LOOKUP, 10'h3FF, 0, 0));
        queue_req(mk(imhq_pkg::OP_REMOVE, 5, 0, 0));
        queue_req(mk(imhq_pkg::OP_INSERT, 10'h3FF, KEY_INF, KEY_INF));
        queue_req(mk(imhq_pkg::OP_INSERT, 0, 0, 0));
        queue_req(mk(imhq_pkg::OP_INSERT, 7, 32'h0001_0000, 32'h5));
        queue_req(mk(imhq_pkg::OP_INSERT, 8, 32'h0001_0000, 32'h3));
        queue_req(mk(imhq_pkg::OP_INSERT, 8, 32'h0001_0000, 32'h3));
        queue_req(mk(imhq_pkg::OP_INSERT, 0, 32'h0002_0000, 0));
        queue_req(mk(imhq_pkg::OP_INSERT, 10'h3FF, 0, 1));
        queue_req(mk(imhq_pkg::OP_LOOKUP, 7, 0, 0));
        queue_req(mk(imhq_pkg::OP_REMOVE, 8, 0, 0));
        queue_req(mk(imhq_pkg::OP_POP, 0, 0, 0));
        queue_req(mk(5, 1, 1, 1));
        queue_req(mk(6, 2, 2, 2));
        queue_req(mk(7, 10'h3FF, KEY_INF, KEY_INF));
        queue_req(mk(imhq_pkg::OP_CLEAR, 0, 0, 0));
        queue_req(mk(imhq_pkg::OP_LOOKUP, 7, 0, 0));
        queue_req(mk(imhq_pkg::OP_POP, 0, 0, 0));
        wait_drained();

        // fill to capacity while the receiver stalls, then hit the full case
        rx_hold = 400;
        for (int i = 0; i < SLOTS; i++)
            queue_req(mk(imhq_pkg::OP_INSERT, i * 3 + 1, rand_key(), rand_key()));
        queue_req(mk(imhq_pkg::OP_INSERT, 2, 0, 0));
        queue_req(mk(imhq_pkg::OP_INSERT, 4, 1, 1));
        queue_req(mk(imhq_pkg::OP_INSERT, 1, 0, 0));
        for (int i = 0; i < 40; i++)
            queue_req(mk(imhq_pkg::OP_POP, 0, 0, 0));
        wait_drained();

        // sender pause until all results are back
        hold_sender = 1;
        wait_drained();
        repeat (50) @(posedge clk);
        hold_sender = 0;

        // random, mostly aimed at vertices in the heap
        for (int n = 0; n < 850; n++)
        begin
            int k;
            k = $urandom_range(0, 99);
            v = (k < 60) ? $urandom_range(0, 63) : $urandom_range(0, 1023);
            if (k < 45)
                queue_req(mk(imhq_pkg::OP_INSERT, v, rand_key(), rand_key()));
            else if (k < 60)
                queue_req(mk(imhq_pkg::OP_REMOVE, v, 0, 0));
            else if (k < 78)
                queue_req(mk(imhq_pkg::OP_POP, v, $urandom(), $urandom()));
            else if (k < 95)
                queue_req(mk(imhq_pkg::OP_LOOKUP, v, $urandom(), $urandom()));
            else if (k < 97)
                queue_req(mk(imhq_pkg::OP_CLEAR, v, $urandom(), $urandom()));
            else
                queue_req(mk($urandom_range(5, 7), v, $urandom(), $urandom()));
            // occasional long sender gap
            if ($urandom_range(0, 99) == 0)
            begin
                wait_drained();
                repeat ($urandom_range(20, 200)) @(posedge clk);
            end
        end
        wait_drained();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/imhq_pkg.sv
rtl/imhq_key_cmp.sv
rtl/indexed_min_heap_queue.sv
bench/indexed_min_heap_queue_tb.sv
